/* hdl/dwc_pkg.sv */
package dwc_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int ACT_W      = 4;
   localparam int STAT_W     = 2;

   typedef logic [ACT_W-1:0]      action_type;
   typedef logic [STAT_W-1:0]     status_type;
   typedef logic [DATA_WIDTH-1:0] word_type;

   localparam action_type ACT_PUSH_HEAD = 4'd0;
   localparam action_type ACT_PUSH_TAIL = 4'd1;
   localparam action_type ACT_POP_HEAD  = 4'd2;
   localparam action_type ACT_POP_TAIL  = 4'd3;
   localparam action_type ACT_FIRST     = 4'd4;
   localparam action_type ACT_LAST      = 4'd5;
   localparam action_type ACT_NEXT      = 4'd6;
   localparam action_type ACT_PREVIOUS  = 4'd7;
   localparam action_type ACT_DELETE    = 4'd8;
   localparam action_type ACT_GET       = 4'd9;
   localparam action_type ACT_PUT       = 4'd10;

   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_EMPTY = 2'd1;
   localparam status_type STAT_END   = 2'd2;
   localparam status_type STAT_FULL  = 2'd3;

   // Controller to datapath commands.
   typedef struct packed {
      logic load_req;
      logic commit;
   } cmd_type;

endpackage

/* hdl/dwc_ctrl.sv */
module dwc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output dwc_pkg::cmd_type cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.commit   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold the transaction until the result register is free
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_commit_only_in_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (state_ff == S_EXEC))
      else $error("commit outside execute state");
   a_commit_raises_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("result not presented after commit");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !cmd.commit)
      else $error("waiting result overwritten");
`endif

endmodule

/* hdl/dwc_datapath.sv */
module dwc_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  dwc_pkg::cmd_type                cmd,
   input  dwc_pkg::action_type             action,
   input  dwc_pkg::word_type               data_in,
   output dwc_pkg::word_type               data_out,
   output dwc_pkg::status_type             status,
   output logic [dwc_pkg::CNT_W-1:0]       entry_count,
   output logic                            is_empty,
   output logic                            cursor_at_head,
   output logic                            cursor_at_tail
);

   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_WRITE  = 2'd2;
   localparam logic [1:0] OP_UNLINK = 2'd3;

   // latched request
   dwc_pkg::action_type act_ff;
   dwc_pkg::word_type   din_ff;

   // queue state
   dwc_pkg::word_type               store_ff [dwc_pkg::DEPTH];
   dwc_pkg::word_type               store_in [dwc_pkg::DEPTH];
   logic [dwc_pkg::CNT_W-1:0]       occ_ff, occ_in;
   logic [dwc_pkg::IDX_W-1:0]       cur_ff, cur_in;
   logic                            cv_ff, cv_in;

   // result registers
   dwc_pkg::word_type               dout_ff, dout_in;
   dwc_pkg::status_type             st_ff, st_in;
   logic [dwc_pkg::CNT_W-1:0]       cnt_ff;
   logic                            empty_ff, empty_in;
   logic                            head_ff, head_in;
   logic                            tail_ff, tail_in;

   logic [1:0]                      op;
   logic [dwc_pkg::IDX_W-1:0]       op_idx;
   logic [dwc_pkg::IDX_W-1:0]       rd_idx;
   logic                            use_rd;
   dwc_pkg::word_type               rd_data;
   logic [dwc_pkg::CNT_W-1:0]       cur_ext, cur_p1, occ_m1, occ_m2;
   logic                            cur_ok, ok_n;
   logic [dwc_pkg::IDX_W-1:0]       tail_idx;

   assign cur_ext  = {{(dwc_pkg::CNT_W-dwc_pkg::IDX_W){1'b0}}, cur_ff};
   assign cur_p1   = cur_ext + dwc_pkg::CNT_W'(1);
   assign occ_m1   = occ_ff - dwc_pkg::CNT_W'(1);
   assign occ_m2   = occ_ff - dwc_pkg::CNT_W'(2);
   assign tail_idx = occ_m1[dwc_pkg::IDX_W-1:0];
   assign cur_ok   = cv_ff && (cur_ext < occ_ff);
   assign rd_data  = store_ff[rd_idx];

   // action decode
   always_comb begin
      st_in  = dwc_pkg::STAT_OK;
      op     = OP_NONE;
      op_idx = cur_ff;
      rd_idx = cur_ff;
      use_rd = 1'b0;
      occ_in = occ_ff;
      cur_in = cur_ff;
      cv_in  = cv_ff;
      unique case (act_ff)
         dwc_pkg::ACT_PUSH_HEAD, dwc_pkg::ACT_PUSH_TAIL: begin
            if (occ_ff >= dwc_pkg::CNT_W'(dwc_pkg::DEPTH)) begin
               st_in = dwc_pkg::STAT_FULL;
            end else begin
               occ_in = occ_ff + dwc_pkg::CNT_W'(1);
               cv_in  = 1'b1;
               if (act_ff == dwc_pkg::ACT_PUSH_HEAD) begin
                  op     = OP_INSERT;
                  cur_in = '0;
               end else begin
                  op     = OP_WRITE;
                  op_idx = occ_ff[dwc_pkg::IDX_W-1:0];
                  cur_in = occ_ff[dwc_pkg::IDX_W-1:0];
               end
            end
         end
         dwc_pkg::ACT_POP_HEAD, dwc_pkg::ACT_POP_TAIL: begin
            if (occ_ff == '0) begin
               st_in = dwc_pkg::STAT_EMPTY;
            end else begin
               op     = OP_UNLINK;
               op_idx = (act_ff == dwc_pkg::ACT_POP_HEAD) ? '0 : tail_idx;
            end
         end
         dwc_pkg::ACT_DELETE: begin
            if (!cur_ok) begin
               st_in = dwc_pkg::STAT_EMPTY;
            end else begin
               op = OP_UNLINK;
            end
         end
         dwc_pkg::ACT_FIRST, dwc_pkg::ACT_LAST: begin
            if (occ_ff == '0) begin
               st_in = dwc_pkg::STAT_EMPTY;
            end else begin
               cur_in = (act_ff == dwc_pkg::ACT_FIRST) ? '0 : tail_idx;
               cv_in  = 1'b1;
               rd_idx = cur_in;
               use_rd = 1'b1;
            end
         end
         dwc_pkg::ACT_NEXT: begin
            if (!cur_ok) begin
               st_in = dwc_pkg::STAT_EMPTY;
            end else if (cur_p1 >= occ_ff) begin
               st_in = dwc_pkg::STAT_END;
            end else begin
               cur_in = cur_ff + dwc_pkg::IDX_W'(1);
               rd_idx = cur_in;
               use_rd = 1'b1;
            end
         end
         dwc_pkg::ACT_PREVIOUS: begin
            if (!cur_ok) begin
               st_in = dwc_pkg::STAT_EMPTY;
            end else if (cur_ff == '0) begin
               st_in = dwc_pkg::STAT_END;
            end else begin
               cur_in = cur_ff - dwc_pkg::IDX_W'(1);
               rd_idx = cur_in;
               use_rd = 1'b1;
            end
         end
         dwc_pkg::ACT_GET: begin
            if (!cur_ok) begin
               st_in = dwc_pkg::STAT_EMPTY;
            end else begin
               use_rd = 1'b1;
            end
         end
         dwc_pkg::ACT_PUT: begin
            if (!cur_ok) begin
               st_in = dwc_pkg::STAT_EMPTY;
            end else begin
               op = OP_WRITE;
            end
         end
         default: ;
      endcase

      // removal: read the departing word, shrink, settle the cursor
      if (op == OP_UNLINK) begin
         rd_idx = op_idx;
         use_rd = 1'b1;
         occ_in = occ_m1;
         if (occ_m1 == '0) begin
            cv_in  = 1'b0;
            cur_in = '0;
         end else begin
            cv_in  = 1'b1;
            cur_in = ({1'b0, op_idx} < occ_m1) ? op_idx : occ_m2[dwc_pkg::IDX_W-1:0];
         end
      end

      if (st_in != dwc_pkg::STAT_OK) begin
         dout_in = '0;
      end else if (use_rd) begin
         dout_in = rd_data;
      end else if (op != OP_NONE) begin
         dout_in = din_ff;
      end else begin
         dout_in = '0;
      end

      ok_n     = cv_in && ({{(dwc_pkg::CNT_W-dwc_pkg::IDX_W){1'b0}}, cur_in} < occ_in);
      empty_in = (occ_in == '0);
      head_in  = ok_n && (cur_in == '0);
      tail_in  = ok_n && (({{(dwc_pkg::CNT_W-dwc_pkg::IDX_W){1'b0}}, cur_in}
                           + dwc_pkg::CNT_W'(1)) == occ_in);
   end

   // entry shifting: insert at head, write in place, or close a gap
   always_comb begin
      store_in = store_ff;
      unique case (op)
         OP_INSERT: begin
            store_in[0] = din_ff;
            for (int i = 1; i < dwc_pkg::DEPTH; i++) begin
               store_in[i] = store_ff[i-1];
            end
         end
         OP_WRITE: store_in[op_idx] = din_ff;
         OP_UNLINK: begin
            for (int i = 0; i < dwc_pkg::DEPTH - 1; i++) begin
               if (dwc_pkg::IDX_W'(i) >= op_idx) begin
                  store_in[i] = store_ff[i+1];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
         cur_ff <= '0;
         cv_ff  <= 1'b0;
      end else if (cmd.commit) begin
         occ_ff <= occ_in;
         cur_ff <= cur_in;
         cv_ff  <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff <= action;
         din_ff <= data_in;
      end
      if (cmd.commit) begin
         store_ff <= store_in;
         dout_ff  <= dout_in;
         st_ff    <= st_in;
         cnt_ff   <= occ_in;
         empty_ff <= empty_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   assign data_out       = dout_ff;
   assign status         = st_ff;
   assign entry_count    = cnt_ff;
   assign is_empty       = empty_ff;
   assign cursor_at_head = head_ff;
   assign cursor_at_tail = tail_ff;

`ifndef NO_ASSERTIONS
   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= dwc_pkg::CNT_W'(dwc_pkg::DEPTH))
      else $error("occupancy beyond depth");
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cv_ff |-> (cur_ext < occ_ff))
      else $error("valid cursor outside held entries");
   a_empty_no_cursor: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> !cv_ff)
      else $error("cursor valid on empty queue");
   a_fail_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && st_in != dwc_pkg::STAT_OK) |=>
      (occ_ff == $past(occ_ff) && cv_ff == $past(cv_ff)))
      else $error("failed action changed queue state");
`endif

endmodule

/* hdl/deque_with_cursor_core.sv */
// Bounded double-ended queue of 32-bit words (16 entries) with a cursor.
// Each request transaction carries one action: push or pop at head or
// tail, move the cursor (first, last, next toward tail, previous toward
// head), delete the entry under the cursor, get it, or put a new word there.
// Every action returns exactly one response transaction with the word,
// a status (ok, empty or no cursor, already at end, full), the entry count
// and the empty/at-head/at-tail flags. An action runs in order: the request
// is latched, then the entry register array shifts or writes in parallel and
// the response register loads; the next request is taken in the cycle after
// that, so a new action is not taken before the last one has executed. A
// waiting response holds the execute step, and with it the request side,
// until it is taken.
// The entry array has no reset; entries beyond the count are never read.
module deque_with_cursor_core (
   input  logic        clock,
   input  logic        reset,
   // request: [3:0] action, [35:4] data_in, [39:36] zero
   input  logic [39:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // response: [31:0] data_out, [33:32] status, [38:34] entry_count,
   // [39] is_empty, [40] cursor_at_head, [41] cursor_at_tail, [47:42] zero
   output logic [47:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);

   dwc_pkg::cmd_type                cmd;
   dwc_pkg::word_type               data_out;
   dwc_pkg::status_type             status;
   logic [dwc_pkg::CNT_W-1:0]       entry_count;
   logic                            is_empty;
   logic                            cursor_at_head;
   logic                            cursor_at_tail;

   // sequencing: latch, execute, present
   dwc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // queue storage, cursor and response registers
   dwc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .action         (req_tdata[3:0]),
      .data_in        (req_tdata[35:4]),
      .data_out       (data_out),
      .status         (status),
      .entry_count    (entry_count),
      .is_empty       (is_empty),
      .cursor_at_head (cursor_at_head),
      .cursor_at_tail (cursor_at_tail)
   );

   // pack the response, highest field first
   assign rsp_tdata = {6'b0, cursor_at_tail, cursor_at_head, is_empty,
                       entry_count, status, data_out};

endmodule

/* dv/tb_deque_with_cursor_core.sv */
`timescale 1ns / 1ps

module tb_deque_with_cursor_core;

   localparam int REQ_W = 40;
   localparam int RSP_W = 48;

   typedef struct packed {
      dwc_pkg::word_type          data;
      dwc_pkg::status_type        status;
      logic [dwc_pkg::CNT_W-1:0]  count;
      logic                       empty;
      logic                       at_head;
      logic                       at_tail;
   } response_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;

   // Shadow copy of the deque, updated as each request is accepted.
   dwc_pkg::word_type deque_words [dwc_pkg::DEPTH];
   int unsigned       deque_held;
   int unsigned       cursor_idx;
   bit                cursor_live;

   response_type awaited_responses [$];

   int unsigned req_gap_pct;
   int unsigned rsp_stall_pct;
   int unsigned rsp_hold_cycles;

   int unsigned errors;
   int unsigned actions_sent;
   int unsigned responses_seen;
   int unsigned full_hits;
   int unsigned empty_hits;
   int unsigned end_hits;
   int unsigned peak_held;

   dwc_pkg::action_type cursor_actions [6] = '{dwc_pkg::ACT_FIRST, dwc_pkg::ACT_LAST,
                                               dwc_pkg::ACT_NEXT, dwc_pkg::ACT_PREVIOUS,
                                               dwc_pkg::ACT_GET, dwc_pkg::ACT_PUT};

   deque_with_cursor_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #5 clock = ~clock;

   // Remove one entry, close the gap and park the cursor on the old
   // tail-side neighbour (or on the new tail).
   function automatic dwc_pkg::word_type unlink_entry(int unsigned idx);
      dwc_pkg::word_type w;
      w = deque_words[idx];
      for (int unsigned i = idx; i + 1 < deque_held; i++)
         deque_words[i] = deque_words[i + 1];
      deque_held--;
      if (deque_held == 0) begin
         cursor_live = 1'b0;
         cursor_idx  = 0;
      end else begin
         cursor_live = 1'b1;
         cursor_idx  = (idx < deque_held) ? idx : deque_held - 1;
      end
      return w;
   endfunction

   function automatic void apply_deque_action(dwc_pkg::action_type act,
                                              dwc_pkg::word_type din);
      response_type r;
      bit           on_entry;
      r        = '0;
      r.status = dwc_pkg::STAT_OK;
      on_entry = cursor_live && cursor_idx < deque_held;
      case (act)
         dwc_pkg::ACT_PUSH_HEAD, dwc_pkg::ACT_PUSH_TAIL: begin
            if (deque_held >= dwc_pkg::DEPTH) begin
               r.status = dwc_pkg::STAT_FULL;
            end else begin
               if (act == dwc_pkg::ACT_PUSH_HEAD) begin
                  for (int unsigned i = deque_held; i > 0; i--)
                     deque_words[i] = deque_words[i - 1];
                  deque_words[0] = din;
                  cursor_idx     = 0;
               end else begin
                  deque_words[deque_held] = din;
                  cursor_idx              = deque_held;
               end
               deque_held++;
               cursor_live = 1'b1;
               r.data      = din;
            end
         end
         dwc_pkg::ACT_POP_HEAD, dwc_pkg::ACT_POP_TAIL: begin
            if (deque_held == 0)
               r.status = dwc_pkg::STAT_EMPTY;
            else
               r.data = unlink_entry((act == dwc_pkg::ACT_POP_HEAD) ? 0 : deque_held - 1);
         end
         dwc_pkg::ACT_FIRST, dwc_pkg::ACT_LAST: begin
            if (deque_held == 0) begin
               r.status = dwc_pkg::STAT_EMPTY;
            end else begin
               cursor_idx  = (act == dwc_pkg::ACT_FIRST) ? 0 : deque_held - 1;
               cursor_live = 1'b1;
               r.data      = deque_words[cursor_idx];
            end
         end
         dwc_pkg::ACT_NEXT: begin
            if (!on_entry) begin
               r.status = dwc_pkg::STAT_EMPTY;
            end else if (cursor_idx + 1 >= deque_held) begin
               r.status = dwc_pkg::STAT_END;
            end else begin
               cursor_idx++;
               r.data = deque_words[cursor_idx];
            end
         end
         dwc_pkg::ACT_PREVIOUS: begin
            if (!on_entry) begin
               r.status = dwc_pkg::STAT_EMPTY;
            end else if (cursor_idx == 0) begin
               r.status = dwc_pkg::STAT_END;
            end else begin
               cursor_idx--;
               r.data = deque_words[cursor_idx];
            end
         end
         dwc_pkg::ACT_DELETE: begin
            if (!on_entry)
               r.status = dwc_pkg::STAT_EMPTY;
            else
               r.data = unlink_entry(cursor_idx);
         end
         dwc_pkg::ACT_GET: begin
            if (!on_entry)
               r.status = dwc_pkg::STAT_EMPTY;
            else
               r.data = deque_words[cursor_idx];
         end
         dwc_pkg::ACT_PUT: begin
            if (!on_entry) begin
               r.status = dwc_pkg::STAT_EMPTY;
            end else begin
               deque_words[cursor_idx] = din;
               r.data                  = din;
            end
         end
         default: ;
      endcase

      on_entry  = cursor_live && cursor_idx < deque_held;
      r.count   = dwc_pkg::CNT_W'(deque_held);
      r.empty   = (deque_held == 0);
      r.at_head = on_entry && cursor_idx == 0;
      r.at_tail = on_entry && cursor_idx + 1 == deque_held;
      awaited_responses.push_back(r);

      case (r.status)
         dwc_pkg::STAT_FULL:  full_hits++;
         dwc_pkg::STAT_EMPTY: empty_hits++;
         dwc_pkg::STAT_END:   end_hits++;
         default: ;
      endcase
      if (deque_held > peak_held)
         peak_held = deque_held;
   endfunction

   function automatic void compare_field(string name, logic [31:0] exp_val,
                                         logic [31:0] got_val);
      if (exp_val !== got_val) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, got_val);
         errors++;
      end
   endfunction

   function automatic void check_response(logic [RSP_W-1:0] tdata);
      response_type e;
      if (awaited_responses.size() == 0) begin
         $display("%0t: unexpected response: expected none, actual %h", $time, tdata);
         errors++;
         return;
      end
      e = awaited_responses.pop_front();
      responses_seen++;
      compare_field("data_out",       e.data,          tdata[31:0]);
      compare_field("status",         32'(e.status),   32'(tdata[33:32]));
      compare_field("entry_count",    32'(e.count),    32'(tdata[38:34]));
      compare_field("is_empty",       32'(e.empty),    32'(tdata[39]));
      compare_field("cursor_at_head", 32'(e.at_head),  32'(tdata[40]));
      compare_field("cursor_at_tail", 32'(e.at_tail),  32'(tdata[41]));
   endfunction

   // Response side: check each transaction, then choose next cycle's ready.
   // A hold-off, once set, keeps ready low until its counter runs down.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_response(rsp_tdata);
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Offer one request transaction, idling first at random; returns at the
   // edge where it was accepted.
   task automatic issue_action(dwc_pkg::action_type act, dwc_pkg::word_type din);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - dwc_pkg::ACT_W - dwc_pkg::DATA_WIDTH){1'b0}}, din, act};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      apply_deque_action(act, din);
      actions_sent++;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (awaited_responses.size() != 0)
         @(posedge clock);
   endtask

   function automatic dwc_pkg::word_type pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Grow phases favour pushes, shrink phases favour pops and deletes, so
   // the count sweeps between empty and full.
   function automatic dwc_pkg::action_type pick_action(bit grow);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < (grow ? 40 : 12))
         return $urandom_range(0, 1) ? dwc_pkg::ACT_PUSH_HEAD : dwc_pkg::ACT_PUSH_TAIL;
      else if (r < (grow ? 48 : 38))
         return $urandom_range(0, 1) ? dwc_pkg::ACT_POP_HEAD : dwc_pkg::ACT_POP_TAIL;
      else if (r < (grow ? 52 : 52))
         return dwc_pkg::ACT_DELETE;
      else if (r < 97)
         return cursor_actions[$urandom_range(0, 5)];
      else
         return dwc_pkg::action_type'(dwc_pkg::ACT_PUT + $urandom_range(1, 5));
   endfunction

   task automatic test_empty_queue();
      issue_action(dwc_pkg::ACT_POP_HEAD, '0);
      issue_action(dwc_pkg::ACT_POP_TAIL, '1);
      issue_action(dwc_pkg::ACT_FIRST, '0);
      issue_action(dwc_pkg::ACT_NEXT, '0);
      issue_action(dwc_pkg::ACT_DELETE, '0);
      issue_action(dwc_pkg::ACT_PUT, 32'hDEAD_BEEF);
      issue_action(dwc_pkg::action_type'(4'hF), '1);
      wait_for_drain();
   endtask

   task automatic test_cursor_moves();
      issue_action(dwc_pkg::ACT_PUSH_TAIL, '0);
      issue_action(dwc_pkg::ACT_PUSH_HEAD, '1);
      issue_action(dwc_pkg::ACT_PUSH_TAIL, 32'h5A5A_5A5A);
      issue_action(dwc_pkg::ACT_NEXT, '0);        // already on the tail
      issue_action(dwc_pkg::ACT_FIRST, '0);
      issue_action(dwc_pkg::ACT_PREVIOUS, '0);    // already on the head
      issue_action(dwc_pkg::ACT_NEXT, '0);
      issue_action(dwc_pkg::ACT_GET, '0);
      issue_action(dwc_pkg::ACT_PUT, 32'hA5A5_A5A5);
      issue_action(dwc_pkg::ACT_DELETE, '0);      // middle entry
      issue_action(dwc_pkg::ACT_LAST, '0);
      issue_action(dwc_pkg::ACT_DELETE, '0);      // tail entry
      issue_action(dwc_pkg::ACT_POP_HEAD, '0);    // empties, cursor dropped
      issue_action(dwc_pkg::ACT_GET, '0);
      wait_for_drain();
   endtask

   task automatic test_full_queue();
      for (int i = 0; i < dwc_pkg::DEPTH; i++)
         issue_action((i % 2) ? dwc_pkg::ACT_PUSH_HEAD : dwc_pkg::ACT_PUSH_TAIL,
                      pick_word());
      issue_action(dwc_pkg::ACT_PUSH_HEAD, '1);
      issue_action(dwc_pkg::ACT_PUSH_TAIL, '1);
      wait_for_drain();
   endtask

   task automatic test_random_traffic(int unsigned n_items, int unsigned gap_pct,
                                      int unsigned stall_pct);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      for (int unsigned i = 0; i < n_items; i++)
         issue_action(pick_action(((i / 64) % 2) == 0), pick_word());
      wait_for_drain();
   endtask

   // Hold the response side off long enough for the block to back up and
   // drop its request ready while requests keep coming.
   task automatic test_response_backpressure();
      req_gap_pct     = 0;
      rsp_stall_pct   = 0;
      rsp_hold_cycles = 120;
      for (int i = 0; i < 30; i++)
         issue_action(pick_action(1'b1), pick_word());
      wait_for_drain();
   endtask

   initial begin
      errors          = 0;
      req_gap_pct     = 0;
      rsp_stall_pct   = 0;
      rsp_hold_cycles = 0;
      deque_held      = 0;
      cursor_idx      = 0;
      cursor_live     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_cursor_moves();
      test_full_queue();
      test_random_traffic(360, 0, 0);
      test_random_traffic(360, 62, 0);
      test_response_backpressure();
      test_random_traffic(360, 0, 62);
      test_random_traffic(360, 25, 25);

      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("covered %0d actions, %0d responses checked, peak count %0d",
               actions_sent, responses_seen, peak_held);
      $display("status hits: %0d full, %0d empty or no cursor, %0d already at end",
               full_hits, empty_hits, end_hits);
      if (errors == 0 && awaited_responses.size() == 0) begin
         $display("tb_deque_with_cursor_core: done, clean");
      end else begin
         $display("tb_deque_with_cursor_core: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout with %0d responses outstanding", $time,
               awaited_responses.size());
      $display("tb_deque_with_cursor_core: done, errors");
      $finish;
   end

endmodule
